// File: sv/met_pkg.sv
package met_pkg;

   localparam int COUNT_BITS = 16;

   localparam logic [7:0] VALUE_INSIDE = 8'hFF;

   typedef struct packed {
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
   } met_req_type;

   typedef struct packed {
      logic [21:0] pixel_index;
      logic [7:0]  pixel_value;
   } met_rsp_type;

   typedef enum logic [2:0] {
      CSR_IMAGE_WIDTH    = 3'd0,
      CSR_IMAGE_HEIGHT   = 3'd1,
      CSR_MAX_ITERATIONS = 3'd2,
      CSR_CENTER_RE      = 3'd3,
      CSR_CENTER_IM      = 3'd4,
      CSR_ZOOM_STEP      = 3'd5
   } met_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_OFFSET,
      ST_INJECT,
      ST_SPIN
   } met_state_type;

   // control part of the token that travels around the ring of cells
   typedef struct packed {
      logic                  valid;
      logic                  done;
      logic [COUNT_BITS-1:0] count;
      logic [7:0]            value;
   } met_token_type;

endpackage

// File: sv/mandelbrot_escape_time_pixel.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_stall  req_data (met_req_type)
// rsp_      out        rsp_valid / rsp_stall  rsp_data (met_rsp_type)
// csr_      in         csr_valid / csr_ready  csr_index, csr_wdata
//
// One pixel at a time, with k = min(escape count, max_iterations). The pixel is scaled and
// offset into c, injected, and spun for k iterations (each the squarings, then the update);
// the result is captured from the ring's tail, and the next pixel can be taken as it shows.
// Reset is synchronous and restores the register defaults; the ring comes up empty.
// A finished result waits in the output register; a stalled output keeps the
// next finished token circling the ring, a full lap per miss, until the register frees up.
module mandelbrot_escape_time_pixel import met_pkg::*; #(
   parameter int WIDTH     = 32,
   parameter int FRAC_BITS = 24,
   parameter int NUM_CELLS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  met_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output met_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [11:0]             img_w_ff;
   logic [11:0]             img_h_ff;
   logic [COUNT_BITS-1:0]   max_iter_ff;
   logic signed [31:0]      center_re_ff;
   logic signed [31:0]      center_im_ff;
   logic [30:0]             zoom_ff;

   met_state_type           state_ff;
   met_state_type           state_in;
   logic                    inject;
   logic                    capture;
   logic                    accept;

   logic signed [WIDTH-1:0] c_re;
   logic signed [WIDTH-1:0] c_im;
   logic [21:0]             pixel_index;

   met_token_type           link_tok [NUM_CELLS+1];
   logic signed [WIDTH-1:0] link_re  [NUM_CELLS+1];
   logic signed [WIDTH-1:0] link_im  [NUM_CELLS+1];

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   met_rsp_type             rsp_data_ff;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff     <= 12'd640;
         img_h_ff     <= 12'd480;
         max_iter_ff  <= 16'd255;
         center_re_ff <= '0;
         center_im_ff <= '0;
         zoom_ff      <= 31'd65536;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:    img_w_ff     <= csr_wdata[11:0];
            CSR_IMAGE_HEIGHT:   img_h_ff     <= csr_wdata[11:0];
            CSR_MAX_ITERATIONS: max_iter_ff  <= csr_wdata[15:0];
            CSR_CENTER_RE:      center_re_ff <= csr_wdata;
            CSR_CENTER_IM:      center_im_ff <= csr_wdata;
            CSR_ZOOM_STEP:      zoom_ff      <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   met_map #(
      .WIDTH (WIDTH)
   ) u_map (
      .clock        (clock),
      .load         (accept),
      .pixel        (req_data),
      .image_width  (img_w_ff),
      .image_height (img_h_ff),
      .center_re    (center_re_ff),
      .center_im    (center_im_ff),
      .zoom_step    (zoom_ff),
      .c_re         (c_re),
      .c_im         (c_im),
      .pixel_index  (pixel_index)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      inject   = 1'b0;
      capture  = 1'b0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE:  state_in = ST_OFFSET;
         ST_OFFSET: state_in = ST_INJECT;
         ST_INJECT: begin
            inject   = 1'b1;
            state_in = ST_SPIN;
         end
         ST_SPIN: begin
            capture = link_tok[NUM_CELLS].valid && link_tok[NUM_CELLS].done
                      && (!rsp_valid_ff || !rsp_stall);
            if (capture) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // close the ring: seed a fresh token or feed the tail back, drop it on capture
   always_comb begin
      link_tok[0] = link_tok[NUM_CELLS];
      link_re[0]  = link_re[NUM_CELLS];
      link_im[0]  = link_im[NUM_CELLS];
      if (capture) begin
         link_tok[0].valid = 1'b0;
      end
      if (inject) begin
         link_tok[0] = '{valid: 1'b1, done: 1'b0, count: '0, value: '0};
         link_re[0]  = c_re;
         link_im[0]  = c_im;
      end
   end

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      met_cell #(
         .WIDTH     (WIDTH),
         .FRAC_BITS (FRAC_BITS)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .max_iterations (max_iter_ff),
         .c_re           (c_re),
         .c_im           (c_im),
         .up_tok         (link_tok[i]),
         .up_re          (link_re[i]),
         .up_im          (link_im[i]),
         .dn_tok         (link_tok[i+1]),
         .dn_re          (link_re[i+1]),
         .dn_im          (link_im[i+1])
      );
   end

   assign rsp_valid_in = capture || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (capture) begin
         rsp_data_ff.pixel_index <= pixel_index;
         rsp_data_ff.pixel_value <= link_tok[NUM_CELLS].value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: sv/met_map.sv
module met_map import met_pkg::*; #(
   parameter int WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    load,
   input  met_req_type             pixel,
   input  logic [11:0]             image_width,
   input  logic [11:0]             image_height,
   input  logic signed [31:0]      center_re,
   input  logic signed [31:0]      center_im,
   input  logic [30:0]             zoom_step,
   output logic signed [WIDTH-1:0] c_re,
   output logic signed [WIDTH-1:0] c_im,
   output logic [21:0]             pixel_index
);

   logic [10:0]             x_ff;
   logic [10:0]             y_ff;
   logic signed [12:0]      dx;
   logic signed [12:0]      dy;
   logic signed [31:0]      zoom_s;
   logic [22:0]             index_full;
   logic signed [44:0]      prod_re_ff;
   logic signed [44:0]      prod_im_ff;
   logic [21:0]             index_ff;
   logic signed [WIDTH-1:0] c_re_ff;
   logic signed [WIDTH-1:0] c_im_ff;

   // offsets from the image center in pixels; the im axis runs bottom up
   always_comb begin
      dx = $signed({2'b00, x_ff}) - $signed({2'b00, image_width[11:1]});
      dy = $signed({1'b0, image_height}) - $signed({2'b00, image_height[11:1]})
           - $signed({2'b00, y_ff});
      zoom_s = $signed({1'b0, zoom_step});
      index_full = 23'(x_ff) + 23'(y_ff) * 23'(image_width);
   end

   // user holds inputs while an item is in flight, unchecked; stages run free
   always_ff @(posedge clock) begin
      if (load) begin
         x_ff <= pixel.pixel_x;
         y_ff <= pixel.pixel_y;
      end
      prod_re_ff <= zoom_s * dx;
      prod_im_ff <= zoom_s * dy;
      index_ff   <= index_full[21:0];
      c_re_ff    <= WIDTH'(center_re) + WIDTH'(prod_re_ff);
      c_im_ff    <= WIDTH'(center_im) + WIDTH'(prod_im_ff);
   end

   assign c_re        = c_re_ff;
   assign c_im        = c_im_ff;
   assign pixel_index = index_ff;

endmodule

// File: sv/met_cell.sv
module met_cell import met_pkg::*; #(
   parameter int WIDTH     = 32,
   parameter int FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [COUNT_BITS-1:0]   max_iterations,
   input  logic signed [WIDTH-1:0] c_re,
   input  logic signed [WIDTH-1:0] c_im,
   input  met_token_type           up_tok,
   input  logic signed [WIDTH-1:0] up_re,
   input  logic signed [WIDTH-1:0] up_im,
   output met_token_type           dn_tok,
   output logic signed [WIDTH-1:0] dn_re,
   output logic signed [WIDTH-1:0] dn_im
);

   localparam int PW = 2 * WIDTH;
   localparam int CW = (WIDTH + 1 > FRAC_BITS + 4) ? WIDTH + 1 : FRAC_BITS + 4;
   localparam logic signed [CW-1:0] FOUR = CW'(4) << FRAC_BITS;

   function automatic logic signed [WIDTH-1:0] fix_mul(
      input logic signed [WIDTH-1:0] a,
      input logic signed [WIDTH-1:0] b
   );
      logic signed [PW-1:0] p;
      p = a * b;
      return WIDTH'(p >>> FRAC_BITS);
   endfunction

   met_token_type           tok1_ff;
   logic signed [WIDTH-1:0] rr_ff;
   logic signed [WIDTH-1:0] ii_ff;
   logic signed [WIDTH-1:0] ri_ff;
   met_token_type           tok2_in;
   met_token_type           tok2_ff;
   logic signed [WIDTH-1:0] re2_in;
   logic signed [WIDTH-1:0] im2_in;
   logic signed [WIDTH-1:0] re2_ff;
   logic signed [WIDTH-1:0] im2_ff;
   logic signed [CW-1:0]    mag2;
   logic                    escape;

   // first half: the three squarings
   always_ff @(posedge clock) begin
      if (reset) begin
         tok1_ff <= '0;
      end else begin
         tok1_ff <= up_tok;
      end
      rr_ff <= fix_mul(up_re, up_re);
      ii_ff <= fix_mul(up_im, up_im);
      ri_ff <= fix_mul(up_re, up_im);
   end

   // second half: iteration cap and escape test on the unwrapped sum, then the update
   always_comb begin
      mag2    = CW'(rr_ff) + CW'(ii_ff);
      escape  = mag2 > FOUR;
      tok2_in = tok1_ff;
      if (tok1_ff.valid && !tok1_ff.done) begin
         if (tok1_ff.count == max_iterations) begin
            tok2_in.done  = 1'b1;
            tok2_in.value = VALUE_INSIDE;
         end else if (escape) begin
            tok2_in.done  = 1'b1;
            tok2_in.value = tok1_ff.count[7:0];
         end else begin
            tok2_in.count = tok1_ff.count + COUNT_BITS'(1);
         end
      end
      re2_in = rr_ff - ii_ff + c_re;
      im2_in = (ri_ff <<< 1) + c_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok2_ff <= '0;
      end else begin
         tok2_ff <= tok2_in;
      end
      re2_ff <= re2_in;
      im2_ff <= im2_in;
   end

   assign dn_tok = tok2_ff;
   assign dn_re  = re2_ff;
   assign dn_im  = im2_ff;

endmodule

// File: sv/met_checker.sv
module met_checker import met_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input met_rsp_type rsp_data
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // an accepted pixel keeps the input side busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accepting a pixel");

   // a new result only comes out of a busy engine
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a pixel in flight");

   // the engine frees up only by delivering its result
   a_free_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid)
      else $error("engine went idle without a result");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (.*);
